// ===== hw/rtl/sfm_pkg.sv =====
// Shared types and constants for the substring first-match finder.
// No dependencies.
package sfm_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int PLEN_W     = 5;
    localparam int PAT_BYTES  = 16;
    localparam int PIDX_W     = $clog2(PAT_BYTES);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte NUL_BYTE = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LO    = 2'd0,
        REG_PAT_HI    = 2'd1,
        REG_PAT_LEN   = 2'd2,
        REG_START_POS = 2'd3
    } t_cfg_reg;

endpackage

// ===== hw/rtl/sfm_cell.sv =====
// One window cell: holds one text byte and compares the byte entering it
// with its aligned pattern byte. Depends on sfm_pkg.
module sfm_cell (
    input  logic          i_clk,
    input  logic          i_shift_en,
    input  sfm_pkg::t_byte i_d,
    input  sfm_pkg::t_byte i_pat,
    input  logic          i_in_use,
    output sfm_pkg::t_byte o_q,
    output logic          o_ok
);
    import sfm_pkg::*;

    t_byte r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift_en) begin
            r_q <= i_d;
        end
    end

    assign o_q  = r_q;
    assign o_ok = !i_in_use || (i_d == i_pat);

endmodule

// ===== hw/rtl/substring_first_match_finder_unit.sv =====
// Substring first-match finder: top level, config registers, cell row,
// result stage and output register. Depends on sfm_pkg and sfm_cell.
// Throughput: one text item per cycle while the input is not stalled.
// The result for the last item passes the compare/count stage register and then the
// result register; input stalls only while a last item waits behind a stalled result.
// Reset (synchronous, active low) clears the counter, the found flag and the valids, the
// pattern registers and length to 0, and the start position to 1.
module substring_first_match_finder_unit #(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 65535
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sfm_pkg::BYTE_W-1:0]        i_text_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfm_pkg::POS_W-1:0]         o_match_position,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sfm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sfm_pkg::*;

    localparam int CNT_W = $clog2(TEXT_MAX + 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(TEXT_MAX);

    // config registers
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [PLEN_W-1:0]     r_pat_len;
    logic [POS_W-1:0]      r_start;

    // text state
    logic [CNT_W-1:0]      r_count;
    logic                  r_s1_valid;
    logic                  r_s1_last;
    logic                  r_s1_hit;
    logic                  r_s1_empty;
    logic [POS_W-1:0]      r_s1_s;
    logic [POS_W-1:0]      r_s1_empty_pos;
    logic                  r_found;
    logic [POS_W-1:0]      r_found_pos;
    logic                  r_out_valid;
    logic [POS_W-1:0]      r_out_pos;

    logic [2*CFG_DATA_W-1:0] w_pat_all;
    t_byte                 w_pat [PAT_BYTES];
    logic [PLEN_W-1:0]     w_len_cap;
    logic [PLEN_W-1:0]     w_plen;
    t_byte                 w_align [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_use;
    logic [PATTERN_MAX-1:0] w_ok;
    t_byte                 w_d [PATTERN_MAX];

    logic                  w_accept;
    logic                  w_hold;
    logic                  w_s1_done;
    logic                  w_active;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      w_plen_ext;
    logic [CNT_W-1:0]      w_s;
    logic                  w_hit;
    logic [POS_W-1:0]      w_empty_pos;
    logic [POS_W-1:0]      w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
            r_start   <= POS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PAT_LO:    r_pat_lo  <= i_cfg_data;
                REG_PAT_HI:    r_pat_hi  <= i_cfg_data;
                REG_PAT_LEN:   r_pat_len <= i_cfg_data[PLEN_W-1:0];
                REG_START_POS: r_start   <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // pattern bytes and effective length (cut at first NUL)
    assign w_pat_all = {r_pat_hi, r_pat_lo};

    always_comb begin
        for (int k = 0; k < PAT_BYTES; k++) begin
            w_pat[k] = w_pat_all[BYTE_W*k +: BYTE_W];
        end
    end

    always_comb begin
        w_len_cap = (r_pat_len > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : r_pat_len;
        w_plen    = w_len_cap;
        for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
            if ((PLEN_W'(k) < w_len_cap) && (w_pat[k] == NUL_BYTE)) begin
                w_plen = PLEN_W'(k);
            end
        end
    end

    // cell j sees window byte j, compared with pattern byte plen-1-j
    always_comb begin
        logic [PLEN_W-1:0] idx;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            idx        = w_plen - PLEN_W'(j) - PLEN_W'(1);
            w_use[j]   = PLEN_W'(j) < w_plen;
            w_align[j] = w_pat[idx[PIDX_W-1:0]];
        end
    end

    assign w_d[0] = i_text_byte;

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        if (j < PATTERN_MAX - 1) begin : g_mid
            sfm_cell u_cell (
                .i_clk      (i_clk),
                .i_shift_en (w_accept && w_active),
                .i_d        (w_d[j]),
                .i_pat      (w_align[j]),
                .i_in_use   (w_use[j]),
                .o_q        (w_d[j+1]),
                .o_ok       (w_ok[j])
            );
        end else begin : g_end
            sfm_cell u_cell (
                .i_clk      (i_clk),
                .i_shift_en (w_accept && w_active),
                .i_d        (w_d[j]),
                .i_pat      (w_align[j]),
                .i_in_use   (w_use[j]),
                .o_q        (),
                .o_ok       (w_ok[j])
            );
        end
    end

    // handshake
    assign w_hold     = r_s1_valid && r_s1_last && r_out_valid && i_out_stall;
    assign o_in_stall = w_hold;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_s1_done  = r_s1_valid && !w_hold;

    // stage 1: count and window compare
    assign w_active   = r_count != COUNT_MAX;
    assign n_count    = w_active ? r_count + CNT_W'(1) : r_count;
    assign w_plen_ext = CNT_W'(w_plen);
    assign w_s        = n_count - w_plen_ext + CNT_W'(1);
    assign w_hit      = w_active && (w_plen != '0) && (n_count >= w_plen_ext)
                        && (r_start != '0) && (POS_W'(w_s) >= r_start) && (&w_ok);
    assign w_empty_pos = ((r_start != '0) && (r_start <= POS_W'(n_count))) ? r_start : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count    <= i_last_byte ? '0 : n_count;
                r_s1_valid <= 1'b1;
            end else if (w_s1_done) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_last      <= i_last_byte;
            r_s1_hit       <= w_hit;
            r_s1_empty     <= w_plen == '0;
            r_s1_s         <= POS_W'(w_s);
            r_s1_empty_pos <= w_empty_pos;
        end
    end

    // stage 2: first-match tracking and result
    assign w_result = r_s1_empty ? r_s1_empty_pos :
                      r_found    ? r_found_pos :
                      r_s1_hit   ? r_s1_s : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (w_s1_done) begin
            if (r_s1_last) begin
                r_found <= 1'b0;
            end else if (r_s1_hit && !r_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_done && !r_s1_last && r_s1_hit && !r_found) begin
            r_found_pos <= r_s1_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_done && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_done && r_s1_last) begin
            r_out_pos <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_match_position = r_out_pos;

    // checks
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result item without a last text item");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && r_s1_valid && r_s1_last))
        else $error("input stalled without a blocked result");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_found_pos != '0) && (r_found_pos <= POS_W'(COUNT_MAX)))
        else $error("remembered match position out of range");

endmodule
